/* rtl/trial_division_prime_table_assert.svh */
// Assertion macros shared by the prime table RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef TRIAL_DIVISION_PRIME_TABLE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TABLE_ASSERT_SVH

// Same-cycle implication
`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tdpt_pkg.sv */
package tdpt_pkg;

  localparam int unsigned TABLE_DEPTH = 8192;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OUT_CNT_W   = 14;

  localparam logic [VALUE_W-1:0] INSERT_LIMIT_RESET = 32'h001F_FFFF;

  // Request kinds
  localparam logic REQ_TEST_INSERT = 1'b0;
  localparam logic REQ_TEST_ONLY   = 1'b1;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } tdpt_div_res_t;

endpackage

/* rtl/tdpt_if.sv */
// Request channel: candidate and request kind
interface tdpt_req_if import tdpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// Response channel: one result per request
interface tdpt_rsp_if import tdpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 no_divisor;
  logic                 inserted;
  logic                 table_full;
  logic [OUT_CNT_W-1:0] stored_count;

  modport source (output valid, output no_divisor, output inserted, output table_full,
                  output stored_count, input ready);
  modport sink   (input valid, input no_divisor, input inserted, input table_full,
                  input stored_count, output ready);
endinterface

// Configuration write channel: insert limit
interface tdpt_cfg_if import tdpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tdpt_ram.sv */
module tdpt_ram import tdpt_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  logic [VALUE_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output logic [VALUE_W-1:0] rd_data_o
);

  logic [VALUE_W-1:0] mem_q [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/tdpt_div.sv */
module tdpt_div import tdpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] dividend_i,
  input  logic [VALUE_W-1:0] divisor_i,
  output tdpt_div_res_t      res_o
);

  // Restoring division, two quotient bits per cycle; only the remainder is kept.
  // A zero divisor never restores, so the remainder ends as the dividend.
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned STEPS         = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic               busy_q, done_q, zero_q;
  logic [STEP_W-1:0]  step_q;
  logic [VALUE_W-1:0] rem_q, num_q, den_q;
  logic [VALUE_W-1:0] rem_d;

  // Two shift-subtract steps
  always_comb begin
    logic [VALUE_W:0] trial;
    rem_d = rem_q;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      trial = {rem_d, num_q[VALUE_W-1-b]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
      end
      rem_d = trial[VALUE_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_q << BITS_PER_STEP;
      if (step_q == LAST_STEP) begin
        zero_q <= (rem_d == '0);
      end
    end
  end

  assign res_o.busy     = busy_q;
  assign res_o.done     = done_q;
  assign res_o.rem_zero = zero_q;

endmodule

/* rtl/trial_division_prime_table.sv */
// Trial-division prime table.
// Channels: req carries a candidate value and req_type (0 test and insert,
// 1 test only); rsp returns one result per request: no_divisor, inserted,
// table_full and stored_count (entries held after the request). cfg writes
// the insert limit, the largest value that may be appended; it is taken at
// any time but should only change while no request is in flight.
// Each request divides the candidate by the stored entries in turn until one
// divides it, prefetching each entry from a single-port-read table RAM ahead
// of the divider. The divider resolves two bits per cycle. With rsp free, the
// result is valid once the scan has found a divisor or tried every entry (no
// division at all with an empty table), and the next request can be taken as
// soon as the result is registered.
// Only one request is worked on at a time. The result sits in an output
// register; a new request is taken while it waits, but the next result
// holds (and its table write with it) until rsp is free.
// Reset empties the table (count to zero, RAM contents left as they are)
// and restores the insert limit to 0x1FFFFF; no clearing pass is needed.
`include "trial_division_prime_table_assert.svh"

module trial_division_prime_table import tdpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tdpt_cfg_if.sink          cfg,
  tdpt_req_if.sink          req,
  tdpt_rsp_if.source        rsp
);

  typedef enum logic [1:0] {S_IDLE, S_PRIME, S_DIV, S_FIN} state_e;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q, idx_q, nxt_idx;
  logic [VALUE_W-1:0] cand_q, limit_q;
  logic               kind_q, ok_q;
  logic               rsp_valid_q, rsp_nodiv_q, rsp_ins_q, rsp_full_q;
  logic [OUT_CNT_W-1:0] rsp_cnt_q;

  logic               rd_en, wr_en, div_start, ins_req, room, slot_free, req_fire;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  tdpt_div_res_t      div_res;

  assign req.ready = (state_q == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign nxt_idx   = idx_q + 1'b1;
  assign ins_req   = (kind_q == REQ_TEST_INSERT) && ok_q && (cand_q <= limit_q);
  assign room      = (cnt_q < DEPTH_CNT);
  assign slot_free = !rsp_valid_q || rsp.ready;

  // Table RAM read, table write and divider start
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = nxt_idx[ADDR_W-1:0];
    div_start = 1'b0;
    wr_en     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        rd_en   = req_fire;
        rd_addr = '0;
      end
      S_PRIME: begin
        div_start = 1'b1;
        rd_en     = 1'b1;
      end
      S_DIV: begin
        if (div_res.done && !div_res.rem_zero && (idx_q != cnt_q)) begin
          div_start = 1'b1;
          rd_en     = 1'b1;
        end
      end
      S_FIN: begin
        wr_en = slot_free && ins_req && room;
      end
      default: ;
    endcase
  end

  tdpt_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (cand_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tdpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (rd_data),
    .res_o      (div_res)
  );

  // Sequencer, count, limit and response handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      limit_q     <= INSERT_LIMIT_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        limit_q <= cfg.data;
      end
      // Raise on a finished request, drop once the transaction completes
      if (state_q == S_FIN && slot_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            idx_q   <= '0;
            ok_q    <= 1'b1;
            state_q <= (cnt_q == '0) ? S_FIN : S_PRIME;
          end
        end
        S_PRIME: begin
          idx_q   <= nxt_idx;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            if (div_res.rem_zero) begin
              ok_q    <= 1'b0;
              state_q <= S_FIN;
            end else if (idx_q == cnt_q) begin
              state_q <= S_FIN;
            end else begin
              idx_q <= nxt_idx;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            if (wr_en) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request and response payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cand_q <= req.value;
      kind_q <= req.req_type;
    end
    if (state_q == S_FIN && slot_free) begin
      rsp_nodiv_q <= ok_q;
      rsp_ins_q   <= wr_en;
      rsp_full_q  <= ins_req && !room;
      rsp_cnt_q   <= wr_en ? OUT_CNT_W'(cnt_q + 1'b1) : OUT_CNT_W'(cnt_q);
    end
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.no_divisor   = rsp_nodiv_q;
  assign rsp.inserted     = rsp_ins_q;
  assign rsp.table_full   = rsp_full_q;
  assign rsp.stored_count = rsp_cnt_q;

  `TDPT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= DEPTH_CNT, "entry count beyond table depth")
  `TDPT_ASSERT_NOW(a_start_idle, div_start, !div_res.busy, "divider restarted while busy")
  `TDPT_ASSERT_NEXT(a_wr_count, wr_en, cnt_q == $past(cnt_q) + 1'b1, "table write without count step")
  `TDPT_ASSERT_NOW(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q) == S_FIN, "response raised outside finish")
  `TDPT_ASSERT_NOW(a_scan_bound, state_q == S_DIV, idx_q <= cnt_q && idx_q != '0, "scan index outside table")

endmodule

/* dv/testbench.sv */
module testbench import tdpt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One response transaction as seen on the rsp channel
  typedef struct packed {
    logic                 no_divisor;
    logic                 inserted;
    logic                 table_full;
    logic [OUT_CNT_W-1:0] stored_count;
  } verdict_t;

  // Track the prime table and queue the verdict each request should produce
  class prime_table_scoreboard;
    logic [VALUE_W-1:0] prime_store [TABLE_DEPTH];
    int unsigned        primes_held;
    logic [VALUE_W-1:0] insert_limit;
    verdict_t           pending_verdicts [$];
    int unsigned        mismatches;
    int unsigned        requests;
    int unsigned        test_only_seen;
    int unsigned        inserts;

    function new();
      primes_held    = 0;
      insert_limit   = INSERT_LIMIT_RESET;
      mismatches     = 0;
      requests       = 0;
      test_only_seen = 0;
      inserts        = 0;
    endfunction

    function void set_limit(logic [VALUE_W-1:0] lim);
      insert_limit = lim;
    endfunction

    function int unsigned outstanding();
      return pending_verdicts.size();
    endfunction

    // Divide by the held entries in turn until one divides; a zero entry leaves the candidate as remainder
    function void predict_verdict(logic kind, logic [VALUE_W-1:0] cand);
      verdict_t           v;
      int unsigned        k;
      logic [VALUE_W-1:0] rem;
      v            = '0;
      v.no_divisor = 1'b1;
      k            = 0;
      while (v.no_divisor && k < primes_held) begin
        rem = (prime_store[k] == '0) ? cand : cand % prime_store[k];
        if (rem == '0) v.no_divisor = 1'b0;
        k++;
      end
      // Append within the limit; refuse and flag once the table is full
      if (kind == REQ_TEST_INSERT && v.no_divisor && cand <= insert_limit) begin
        if (primes_held < TABLE_DEPTH) begin
          prime_store[primes_held] = cand;
          primes_held++;
          v.inserted = 1'b1;
          inserts++;
        end else begin
          v.table_full = 1'b1;
        end
      end
      v.stored_count = primes_held[OUT_CNT_W-1:0];
      if (kind == REQ_TEST_ONLY) test_only_seen++;
      requests++;
      pending_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Match a response transaction against the oldest queued verdict
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("no_divisor", want.no_divisor, got.no_divisor);
      compare_field("inserted", want.inserted, got.inserted);
      compare_field("table_full", want.table_full, got.table_full);
      compare_field("stored_count", want.stored_count, got.stored_count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tdpt_cfg_if cfg_if ();
  tdpt_req_if req_if ();
  tdpt_rsp_if rsp_if ();

  trial_division_prime_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_if),
    .req    (req_if),
    .rsp    (rsp_if)
  );

  prime_table_scoreboard sb = new();

  int unsigned next_odd;
  int unsigned burst_left;
  bit          gaps_enabled;
  int unsigned limit_writes;
  int unsigned peak_held;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up after a generous bound on the slowest correct run
  initial begin
    #4_000_000;
    $display("** trial_division_prime_table: FAILED **");
    $finish;
  end

  // Sample both channels at the edge where a transaction completes
  always @(posedge clk_i) begin
    verdict_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.no_divisor   = rsp_if.no_divisor;
        got.inserted     = rsp_if.inserted;
        got.table_full   = rsp_if.table_full;
        got.stored_count = rsp_if.stored_count;
        sb.check_verdict(got);
      end
      if (req_if.valid && req_if.ready) begin
        sb.predict_verdict(req_if.req_type, req_if.value);
        if (sb.primes_held > peak_held) peak_held = sb.primes_held;
      end
    end
  end

  // Stall the response side in stretches of differing character
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned step;
    rsp_if.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (step = 0; step < span; step++) begin
        @(posedge clk_i);
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= (step % 7) > 3;
          default: rsp_if.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Present one request and hold it until accepted, then maybe open a gap
  task automatic send_request(logic kind, logic [VALUE_W-1:0] cand);
    int unsigned gap;
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= cand;
    do @(posedge clk_i); while (!req_if.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (gaps_enabled) begin
        gap = $urandom_range(1, 6);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off new requests until every queued verdict has been answered
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic write_insert_limit(logic [VALUE_W-1:0] lim);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= lim;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_limit(lim);
    cfg_if.valid <= 1'b0;
    limit_writes++;
  endtask

  // Mostly feed the next odd number in order; mix in out-of-order and wide values
  task automatic run_phase(int unsigned n_items, bit calm);
    int unsigned pick;
    logic        kind;
    gaps_enabled = !calm;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 1) ? REQ_TEST_ONLY : REQ_TEST_INSERT;
      if (pick < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(REQ_TEST_ONLY, next_odd);
        end else begin
          send_request(REQ_TEST_INSERT, next_odd);
          next_odd += 2;
        end
      end else if (pick < 82) begin
        send_request(kind, $urandom());
      end else if (pick < 94) begin
        send_request(kind, $urandom_range(2, next_odd + 64));
      end else begin
        send_request(REQ_TEST_INSERT, $urandom() | 32'h1);
      end
      if ($urandom_range(0, 24) == 0) drain_results();
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_TEST_INSERT;
    req_if.value    <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    next_odd        = 13;
    burst_left      = 1;
    gaps_enabled    = 1'b1;
    limit_writes    = 0;
    peak_held       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: everything passes, large values stay above the reset limit
    send_request(REQ_TEST_ONLY, 32'hFFFF_FFFF);
    send_request(REQ_TEST_INSERT, 32'hFFFF_FFFF);
    send_request(REQ_TEST_INSERT, 32'h8000_0000);
    // A stored zero divides only a zero candidate
    send_request(REQ_TEST_INSERT, 32'h0);
    send_request(REQ_TEST_ONLY, 32'h0);
    send_request(REQ_TEST_INSERT, 32'h0);
    send_request(REQ_TEST_INSERT, 32'd2);
    send_request(REQ_TEST_INSERT, 32'd3);
    send_request(REQ_TEST_INSERT, 32'd5);
    send_request(REQ_TEST_INSERT, 32'd7);
    send_request(REQ_TEST_INSERT, 32'd9);
    send_request(REQ_TEST_ONLY, 32'd11);
    send_request(REQ_TEST_INSERT, 32'h001F_FFFF);
    send_request(REQ_TEST_ONLY, 32'hFFFF_FFFF);
    send_request(REQ_TEST_INSERT, 32'h0007_FFFF);
    drain_results();

    // Limit boundary: equal is appended, a value above the limit is not
    write_insert_limit(32'd11);
    send_request(REQ_TEST_INSERT, 32'd11);
    send_request(REQ_TEST_INSERT, 32'd13);
    send_request(REQ_TEST_ONLY, 32'd13);
    drain_results();

    // The full-table refusal needs TABLE_DEPTH inserts, far beyond this run;
    // the scoreboard still models it
    write_insert_limit(32'($urandom_range(40, 90)));
    run_phase(28, 1'b0);
    drain_results();
    write_insert_limit(32'hFFFF_FFFF);
    run_phase(26, 1'b1);
    drain_results();
    write_insert_limit(32'h0);
    run_phase(22, 1'b0);
    drain_results();
    write_insert_limit(INSERT_LIMIT_RESET);
    run_phase(24, 1'b0);
    drain_results();

    // Store one: from here on every candidate has a divisor
    send_request(REQ_TEST_INSERT, 32'd1);
    send_request(REQ_TEST_ONLY, 32'd1);
    send_request(REQ_TEST_ONLY, 32'hFFFF_FFFF);
    send_request(REQ_TEST_INSERT, 32'h0007_FFFF);
    send_request(REQ_TEST_INSERT, 32'd2);
    drain_results();
    repeat (40) @(posedge clk_i);

    if (sb.outstanding() != 0) begin
      $display("%0t: %0d responses missing, expected 0 outstanding, got %0d",
               $time, sb.outstanding(), sb.outstanding());
      sb.mismatches++;
    end
    $display("Covered %0d requests (%0d test-only), %0d appended, table peaked at %0d entries;",
             sb.requests, sb.test_only_seen, sb.inserts, peak_held);
    $display("insert limit written %0d times, zero and all-ones among the settings.",
             limit_writes);
    if (sb.mismatches == 0) begin
      $display("** trial_division_prime_table: PASSED **");
    end else begin
      $display("** trial_division_prime_table: FAILED **");
    end
    $finish;
  end

endmodule

/* trial_division_prime_table.f */
+incdir+rtl
rtl/tdpt_pkg.sv
rtl/tdpt_if.sv
rtl/tdpt_ram.sv
rtl/tdpt_div.sv
rtl/trial_division_prime_table.sv
dv/testbench.sv
